// ----- hdl/u8cd_pkg.sv -----
// ----------------------------------------------------------------------------
// u8cd_pkg
// Shared widths, constants and types for the UTF-8 codepoint decoder.
// ----------------------------------------------------------------------------
package u8cd_pkg;

   localparam int unsigned CP_W    = 21;
   localparam int unsigned BYTE_W  = 8;

   // replacement character '?'
   localparam logic [CP_W-1:0] QMARK_CP = CP_W'(63);

   // glyph atlas covers 32..255
   localparam logic [CP_W-1:0] ATLAS_LO = CP_W'(32);
   localparam logic [CP_W-1:0] ATLAS_HI = CP_W'(255);

   // lead and continuation byte patterns
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

   // Results caused by one byte: n_qmark '?' results, then the codepoint
   // if has_cp. Also carries the decoder state left behind.
   typedef struct packed {
      logic [2:0]      n_qmark;
      logic            has_cp;
      logic [CP_W-1:0] cp;
      logic [CP_W-1:0] partial;
      logic [1:0]      cont_exp;
      logic [1:0]      cont_seen;
   } burst_type;

   function automatic logic in_atlas_f(input logic [CP_W-1:0] cp);
      return (cp >= ATLAS_LO) && (cp <= ATLAS_HI);
   endfunction

endpackage

// ----- hdl/utf8_codepoint_decoder.sv -----
// Path: input register, then decode, then output register.
// Throughput: one byte per cycle while each byte gives at most one result and
//   rsp_stall is low; a byte giving k results (k up to 4) holds the input
//   register until its last beat is taken, one result beat per cycle unless stalled.
// Reset: synchronous, active high; clears the beat valids, the result index
//   and the open-sequence state.
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Streaming UTF-8 to codepoint decoder with glyph atlas range flag.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder
   import u8cd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_text_byte,
   input  logic            req_end_of_text,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [CP_W-1:0] rsp_codepoint,
   output logic            rsp_in_atlas,
   output logic            rsp_last_of_text
);

   // input register
   logic            s1_valid_ff, s1_valid_in;
   logic [7:0]      s1_byte_ff;
   logic            s1_end_ff;

   // decoder state
   logic [CP_W-1:0] partial_ff, partial_in;
   logic [1:0]      exp_ff, exp_in;
   logic [1:0]      seen_ff, seen_in;

   // index of the next result within the current byte's burst
   logic [1:0]      idx_ff, idx_in;

   // output register
   logic            out_valid_ff, out_valid_in;
   logic [CP_W-1:0] out_cp_ff, out_cp_in;
   logic            out_atlas_ff, out_atlas_in;
   logic            out_last_ff, out_last_in;

   burst_type       burst;
   logic [2:0]      total;
   logic            is_last_idx;
   logic            out_free;
   logic            emit;
   logic            s1_done;
   logic [CP_W-1:0] sel_cp;

   // ---------------- decode of the registered byte ----------------
   always_comb begin
      logic            cont;
      logic [1:0]      seen_inc;
      logic [CP_W-1:0] shifted;
      burst = '0;
      cont     = (s1_byte_ff & CONT_MASK) == CONT_CODE;
      seen_inc = seen_ff + 2'd1;
      shifted  = {partial_ff[CP_W-7:0], s1_byte_ff[5:0]};
      if ((exp_ff != 2'd0) && cont) begin
         if (seen_inc == exp_ff) begin
            burst.has_cp = 1'b1;
            burst.cp     = shifted;
         end else begin
            burst.partial   = shifted;
            burst.cont_exp  = exp_ff;
            burst.cont_seen = seen_inc;
         end
      end else begin
         // a broken sequence gives '?' for its lead and each continuation
         if (exp_ff != 2'd0) begin
            burst.n_qmark = 3'd1 + {1'b0, seen_ff};
         end
         priority if (!s1_byte_ff[7]) begin
            burst.has_cp = 1'b1;
            burst.cp     = CP_W'(s1_byte_ff);
         end else if ((s1_byte_ff & LEAD2_MASK) == LEAD2_CODE) begin
            burst.partial  = CP_W'(s1_byte_ff[4:0]);
            burst.cont_exp = 2'd1;
         end else if ((s1_byte_ff & LEAD3_MASK) == LEAD3_CODE) begin
            burst.partial  = CP_W'(s1_byte_ff[3:0]);
            burst.cont_exp = 2'd2;
         end else if ((s1_byte_ff & LEAD4_MASK) == LEAD4_CODE) begin
            burst.partial  = CP_W'(s1_byte_ff[2:0]);
            burst.cont_exp = 2'd3;
         end else begin
            burst.n_qmark = burst.n_qmark + 3'd1;
         end
      end
      // end of text flushes whatever is still open; no codepoint pending then
      if (s1_end_ff && (burst.cont_exp != 2'd0)) begin
         burst.n_qmark   = burst.n_qmark + 3'd1 + {1'b0, burst.cont_seen};
         burst.partial   = '0;
         burst.cont_exp  = 2'd0;
         burst.cont_seen = 2'd0;
      end
   end

   assign total       = burst.n_qmark + {2'b00, burst.has_cp};
   assign is_last_idx = ({1'b0, idx_ff} + 3'd1) == total;
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign emit        = s1_valid_ff && (total != 3'd0) && out_free;
   assign s1_done     = s1_valid_ff && ((total == 3'd0) || (out_free && is_last_idx));
   assign req_stall   = s1_valid_ff && !s1_done;

   // '?' beats come first, the codepoint last
   assign sel_cp = ({1'b0, idx_ff} < burst.n_qmark) ? QMARK_CP : burst.cp;

   // ---------------- next values ----------------
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      partial_in   = partial_ff;
      exp_in       = exp_ff;
      seen_in      = seen_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_cp_in    = out_cp_ff;
      out_atlas_in = out_atlas_ff;
      out_last_in  = out_last_ff;

      if (out_free) begin
         out_valid_in = emit;
      end
      if (emit) begin
         out_cp_in    = sel_cp;
         out_atlas_in = in_atlas_f(sel_cp);
         out_last_in  = s1_end_ff && is_last_idx;
         idx_in       = idx_ff + 2'd1;
      end
      if (s1_done) begin
         partial_in  = burst.partial;
         exp_in      = burst.cont_exp;
         seen_in     = burst.cont_seen;
         idx_in      = 2'd0;
         s1_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         partial_ff   <= '0;
         exp_ff       <= 2'd0;
         seen_ff      <= 2'd0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         partial_ff   <= partial_in;
         exp_ff       <= exp_in;
         seen_ff      <= seen_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_text_byte;
         s1_end_ff  <= req_end_of_text;
      end
      out_cp_ff    <= out_cp_in;
      out_atlas_ff <= out_atlas_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_codepoint    = out_cp_ff;
   assign rsp_in_atlas     = out_atlas_ff;
   assign rsp_last_of_text = out_last_ff;

`ifndef SYNTHESIS
   // result index stays inside the burst of the byte being decoded
   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (total != 3'd0)) |-> ({1'b0, idx_ff} < total))
      else $error("result index past end of burst");

   // an end-of-text byte leaves no sequence open
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_done && s1_end_ff) |=> ((exp_ff == 2'd0) && (seen_ff == 2'd0)))
      else $error("sequence still open after end of text");

   // continuation count stays below the expected count
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      ((seen_ff < exp_ff) || ((exp_ff == 2'd0) && (seen_ff == 2'd0))))
      else $error("continuation count out of range");
`endif

endmodule
